@@ rtl/core/rope_pkg.sv @@
package rope_pkg;

    typedef struct packed {
        logic [19:0]        position;
        logic [6:0]         pair_index;
        logic signed [31:0] first_value;
        logic signed [31:0] second_value;
        logic               tensor_end;
    } rope_in_t;

    typedef struct packed {
        logic signed [31:0] rotated_first;
        logic signed [31:0] rotated_second;
        logic               end_of_tensor;
    } rope_out_t;

    // configuration register indexes
    localparam logic [1:0] REG_LOG2_THETA = 2'd0;
    localparam logic [1:0] REG_HEAD_DIM   = 2'd1;

    localparam logic [23:0] LOG2_THETA_RESET = 24'd870823;
    localparam logic [8:0]  HEAD_DIM_RESET   = 9'd128;

    // pipeline depths of the units
    localparam int DIV_STAGES    = 4;
    localparam int EXP_STAGES    = 16;
    localparam int MOD_STAGES    = 5;
    localparam int MOD_STEPS     = 4;
    localparam int CORDIC_STAGES = 12;
    localparam int CORDIC_STEPS  = 24;

    // angle and CORDIC datapath widths
    localparam int CW = 34;
    localparam int MW = 53;

    localparam logic [32:0] Q30_TWO_PI  = 33'd6746518852;
    localparam logic [32:0] Q30_PI      = 33'd3373259426;
    localparam logic [32:0] Q30_HALF_PI = 33'd1686629713;
    localparam logic [31:0] Q30_GAIN    = 32'd652032874;

    typedef logic [31:0] atan_tab_t [CORDIC_STEPS];

    localparam atan_tab_t ATAN_Q30 = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef logic [31:0] exp_fac_t [EXP_STAGES];

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        n    = n_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // factors 2^(-2^-k) in Q0.32, k = 1..16, by repeated square root
    function automatic exp_fac_t exp_factors();
        exp_fac_t    fac;
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int k = 0; k < EXP_STAGES; k++)
        begin
            c      = isqrt64(c << 32);
            fac[k] = c[31:0];
        end
        return fac;
    endfunction

    localparam exp_fac_t EXP_FAC = exp_factors();

endpackage

@@ rtl/core/rope_div.sv @@
module rope_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] num,
    input  logic [8:0]  den,
    output logic        out_valid,
    output logic [31:0] quot
);

    localparam int ST    = rope_pkg::DIV_STAGES;
    localparam int STEPS = 32 / ST;

    logic [31:0] num_reg  [ST];
    logic [8:0]  rem_reg  [ST];
    logic [ST-1:0] valid_reg;
    logic [31:0] num_next [ST];
    logic [8:0]  rem_next [ST];

    // restoring division, quotient bits shift in where numerator bits leave
    always_comb
    begin
        logic [31:0] n;
        logic [8:0]  r;
        logic [9:0]  tr;
        for (int s = 0; s < ST; s++)
        begin
            if (s == 0)
            begin
                n = num;
                r = '0;
            end
            else
            begin
                n = num_reg[s-1];
                r = rem_reg[s-1];
            end
            for (int k = 0; k < STEPS; k++)
            begin
                tr = {r, n[31]};
                if (tr >= {1'b0, den})
                begin
                    tr = tr - {1'b0, den};
                    n  = {n[30:0], 1'b1};
                end
                else
                begin
                    n = {n[30:0], 1'b0};
                end
                r = tr[8:0];
            end
            num_next[s] = n;
            rem_next[s] = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[ST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < ST; s++)
        begin
            num_reg[s] <= num_next[s];
            rem_reg[s] <= rem_next[s];
        end
    end

    assign out_valid = valid_reg[ST-1];
    assign quot      = num_reg[ST-1];

endmodule

@@ rtl/core/rope_cordic.sv @@
module rope_cordic (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [rope_pkg::CW-1:0] angle,
    input  logic                           negate,
    output logic                           out_valid,
    output logic signed [rope_pkg::CW-1:0] cos_out,
    output logic signed [rope_pkg::CW-1:0] sin_out,
    output logic                           out_negate
);

    localparam int ST  = rope_pkg::CORDIC_STAGES;
    localparam int SPS = rope_pkg::CORDIC_STEPS / ST;
    localparam int CW  = rope_pkg::CW;

    logic signed [CW-1:0] x_reg [ST];
    logic signed [CW-1:0] y_reg [ST];
    logic signed [CW-1:0] z_reg [ST];
    logic [ST-1:0]        neg_reg;
    logic [ST-1:0]        valid_reg;
    logic signed [CW-1:0] x_next [ST];
    logic signed [CW-1:0] y_next [ST];
    logic signed [CW-1:0] z_next [ST];

    always_comb
    begin
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] at;
        for (int s = 0; s < ST; s++)
        begin
            if (s == 0)
            begin
                x = $signed({{(CW-32){1'b0}}, rope_pkg::Q30_GAIN});
                y = '0;
                z = angle;
            end
            else
            begin
                x = x_reg[s-1];
                y = y_reg[s-1];
                z = z_reg[s-1];
            end
            for (int k = 0; k < SPS; k++)
            begin
                dx = y >>> (s * SPS + k);
                dy = x >>> (s * SPS + k);
                at = $signed({{(CW-32){1'b0}}, rope_pkg::ATAN_Q30[s * SPS + k]});
                if (!z[CW-1])
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - at;
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + at;
                end
            end
            x_next[s] = x;
            y_next[s] = y;
            z_next[s] = z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[ST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= {neg_reg[ST-2:0], negate};
        for (int s = 0; s < ST; s++)
        begin
            x_reg[s] <= x_next[s];
            y_reg[s] <= y_next[s];
            z_reg[s] <= z_next[s];
        end
    end

    assign out_valid  = valid_reg[ST-1];
    assign cos_out    = x_reg[ST-1];
    assign sin_out    = y_reg[ST-1];
    assign out_negate = neg_reg[ST-1];

endmodule

@@ rtl/core/rotary_position_embedding.sv @@
// Rotary position embedding, rotate-half form, for one component pair per word.
// Input channel: a word (position, pair index, two Q16.16 values, tensor-end flag)
//   is taken at a clock edge with start high and busy low. busy is high only in
//   the first cycle after reset, so a new word can enter every cycle.
// Result channel: result_valid marks each result word for exactly one cycle;
//   the receiver cannot stall it, and none is needed since nothing backs up.
// Pipeline: from the accepting edge to the result cycle a word passes the chain
//   numerator -> exponent divider -> exp2 factor multipliers -> shift, angle
//   multiply and modulo-2*pi reduction -> fold -> CORDIC -> rotate and saturate.
// Throughput: one word per cycle; words are independent and never reordered.
// Configuration: cfg_valid / cfg_ready write channel, index 0 is log2_theta
//   (Q8.16), index 1 is head_dim; other indexes are dropped. Write only while
//   no word is in flight. log2_theta feeds the numerator, head_dim the divider.
// Reset: asynchronous, active low; clears all valid bits and restores the
//   register defaults (log2_theta 870823, head_dim 128).
module rotary_position_embedding #(
    parameter int MAX_HEAD_DIM = 256,
    parameter int VALUE_BITS   = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rope_pkg::rope_in_t  item,
    output logic                result_valid,
    output rope_pkg::rope_out_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    localparam int CW       = rope_pkg::CW;
    localparam int MW       = rope_pkg::MW;
    localparam int EST      = rope_pkg::EXP_STAGES;
    localparam int MST      = rope_pkg::MOD_STAGES;
    localparam int MSP      = rope_pkg::MOD_STEPS;
    localparam int MOD_TOP  = MST * MSP - 1;
    localparam int SIDE_P   = rope_pkg::DIV_STAGES + EST + 1;
    localparam int SIDE_AB  = SIDE_P + 1 + MST + 1 + rope_pkg::CORDIC_STAGES;
    localparam int SIDE_END = SIDE_AB + 1;
    localparam int LAT      = SIDE_END + 2;
    localparam int PW       = 2 * CW;
    localparam int SW       = PW + 1;

    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic        busy_reg;
    logic [23:0] log2_theta_reg;
    logic [8:0]  head_dim_reg;
    logic [8:0]  d_eff;
    logic        accept;

    // head_dim clamp into [2, MAX_HEAD_DIM]
    always_comb
    begin
        if (head_dim_reg < 9'd2)
        begin
            d_eff = 9'd2;
        end
        else if (int'(head_dim_reg) > MAX_HEAD_DIM)
        begin
            d_eff = 9'(MAX_HEAD_DIM);
        end
        else
        begin
            d_eff = head_dim_reg;
        end
    end

    assign accept    = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b1;
            log2_theta_reg <= rope_pkg::LOG2_THETA_RESET;
            head_dim_reg   <= rope_pkg::HEAD_DIM_RESET;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    rope_pkg::REG_LOG2_THETA: log2_theta_reg <= cfg_data;
                    rope_pkg::REG_HEAD_DIM:   head_dim_reg   <= cfg_data[8:0];
                    default: ;
                endcase
            end
        end
    end

    // side data delay line: the accepted word, read where each stage needs it
    rope_pkg::rope_in_t side_reg [SIDE_END+1];

    always_ff @(posedge clk)
    begin
        side_reg[0] <= item;
        for (int i = 1; i <= SIDE_END; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // numerator 2 * j * log2_theta
    logic        num_v_reg;
    logic [31:0] num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_v_reg <= 1'b0;
        end
        else
        begin
            num_v_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= {31'(item.pair_index * log2_theta_reg), 1'b0};
    end

    logic        div_v;
    logic [31:0] div_q;

    rope_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (num_v_reg),
        .num       (num_reg),
        .den       (d_eff),
        .out_valid (div_v),
        .quot      (div_q)
    );

    // 2^-frac as a product of constant factors, one multiply per stage
    logic [EST-1:0] exp_v_reg;
    logic [32:0]    exp_r_reg     [EST];
    logic [15:0]    exp_frac_reg  [EST];
    logic [15:0]    exp_whole_reg [EST];
    logic [32:0]    exp_r_next    [EST];

    always_comb
    begin
        logic [32:0] r;
        logic [15:0] f;
        logic [64:0] prod;
        for (int k = 0; k < EST; k++)
        begin
            if (k == 0)
            begin
                r = 33'd1 << 32;
                f = div_q[15:0];
            end
            else
            begin
                r = exp_r_reg[k-1];
                f = exp_frac_reg[k-1];
            end
            prod = 65'(r) * 65'(rope_pkg::EXP_FAC[k]);
            if (f[EST-1-k])
            begin
                exp_r_next[k] = prod[64:32];
            end
            else
            begin
                exp_r_next[k] = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_v_reg <= '0;
        end
        else
        begin
            exp_v_reg <= {exp_v_reg[EST-2:0], div_v};
        end
    end

    always_ff @(posedge clk)
    begin
        exp_frac_reg[0]  <= div_q[15:0];
        exp_whole_reg[0] <= div_q[31:16];
        for (int k = 1; k < EST; k++)
        begin
            exp_frac_reg[k]  <= exp_frac_reg[k-1];
            exp_whole_reg[k] <= exp_whole_reg[k-1];
        end
        for (int k = 0; k < EST; k++)
        begin
            exp_r_reg[k] <= exp_r_next[k];
        end
    end

    // integer part of the exponent as a right shift
    logic        inv_v_reg;
    logic [32:0] inv_reg;
    logic        ang_v_reg;
    logic [50:0] ang_reg;
    logic [52:0] ang_prod;

    assign ang_prod = 53'(side_reg[SIDE_P].position) * 53'(inv_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_v_reg <= 1'b0;
            ang_v_reg <= 1'b0;
        end
        else
        begin
            inv_v_reg <= exp_v_reg[EST-1];
            ang_v_reg <= inv_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exp_whole_reg[EST-1] >= 16'd33)
        begin
            inv_reg <= '0;
        end
        else
        begin
            inv_reg <= exp_r_reg[EST-1] >> exp_whole_reg[EST-1][5:0];
        end
        ang_reg <= ang_prod[52:2];
    end

    // modulo 2*pi by restoring reduction, MSP quotient bits per stage
    logic [MST-1:0] mod_v_reg;
    logic [MW-1:0]  mod_reg  [MST];
    logic [MW-1:0]  mod_next [MST];

    always_comb
    begin
        logic [MW-1:0] v;
        logic [MW-1:0] sub;
        for (int s = 0; s < MST; s++)
        begin
            if (s == 0)
            begin
                v = MW'(ang_reg);
            end
            else
            begin
                v = mod_reg[s-1];
            end
            for (int m = 0; m < MSP; m++)
            begin
                sub = MW'(rope_pkg::Q30_TWO_PI) << (MOD_TOP - s * MSP - m);
                if (v >= sub)
                begin
                    v = v - sub;
                end
            end
            mod_next[s] = v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_v_reg <= '0;
        end
        else
        begin
            mod_v_reg <= {mod_v_reg[MST-2:0], ang_v_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < MST; s++)
        begin
            mod_reg[s] <= mod_next[s];
        end
    end

    // fold into [-pi/2, pi/2], remember the sign flip
    logic                 fold_v_reg;
    logic signed [CW-1:0] fold_t_reg;
    logic                 fold_neg_reg;
    logic signed [CW:0]   fold_t;
    logic                 fold_neg;

    always_comb
    begin
        fold_t   = $signed((CW+1)'(mod_reg[MST-1]));
        fold_neg = 1'b0;
        if (fold_t > $signed((CW+1)'(rope_pkg::Q30_PI)))
        begin
            fold_t = fold_t - $signed((CW+1)'(rope_pkg::Q30_TWO_PI));
        end
        priority if (fold_t > $signed((CW+1)'(rope_pkg::Q30_HALF_PI)))
        begin
            fold_t   = fold_t - $signed((CW+1)'(rope_pkg::Q30_PI));
            fold_neg = 1'b1;
        end
        else if (fold_t < -$signed((CW+1)'(rope_pkg::Q30_HALF_PI)))
        begin
            fold_t   = fold_t + $signed((CW+1)'(rope_pkg::Q30_PI));
            fold_neg = 1'b1;
        end
        else
        begin
            fold_neg = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_v_reg <= 1'b0;
        end
        else
        begin
            fold_v_reg <= mod_v_reg[MST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        fold_t_reg   <= fold_t[CW-1:0];
        fold_neg_reg <= fold_neg;
    end

    logic                 cor_v;
    logic signed [CW-1:0] cor_cos;
    logic signed [CW-1:0] cor_sin;
    logic                 cor_neg;

    rope_cordic u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (fold_v_reg),
        .angle      (fold_t_reg),
        .negate     (fold_neg_reg),
        .out_valid  (cor_v),
        .cos_out    (cor_cos),
        .sin_out    (cor_sin),
        .out_negate (cor_neg)
    );

    // rotate: four exact products
    logic                 rot_v_reg;
    logic signed [PW-1:0] ax_reg;
    logic signed [PW-1:0] by_reg;
    logic signed [PW-1:0] bx_reg;
    logic signed [PW-1:0] ay_reg;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] va;
    logic signed [CW-1:0] vb;

    assign cx = cor_neg ? -cor_cos : cor_cos;
    assign cy = cor_neg ? -cor_sin : cor_sin;
    assign va = CW'(signed'(side_reg[SIDE_AB].first_value[VALUE_BITS-1:0]));
    assign vb = CW'(signed'(side_reg[SIDE_AB].second_value[VALUE_BITS-1:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_v_reg <= 1'b0;
        end
        else
        begin
            rot_v_reg <= cor_v;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg <= PW'(va) * PW'(cx);
        by_reg <= PW'(vb) * PW'(cy);
        bx_reg <= PW'(vb) * PW'(cx);
        ay_reg <= PW'(va) * PW'(cy);
    end

    // round half up, then saturate
    logic signed [SW-1:0] sum_first;
    logic signed [SW-1:0] sum_second;
    logic signed [SW-1:0] rnd_first;
    logic signed [SW-1:0] rnd_second;
    logic signed [SW-1:0] sat_first;
    logic signed [SW-1:0] sat_second;

    assign sum_first  = SW'(ax_reg) - SW'(by_reg) + (SW'(1) <<< 29);
    assign sum_second = SW'(bx_reg) + SW'(ay_reg) + (SW'(1) <<< 29);
    assign rnd_first  = sum_first >>> 30;
    assign rnd_second = sum_second >>> 30;

    always_comb
    begin
        priority if (rnd_first > SAT_HI)
        begin
            sat_first = SAT_HI;
        end
        else if (rnd_first < SAT_LO)
        begin
            sat_first = SAT_LO;
        end
        else
        begin
            sat_first = rnd_first;
        end
        priority if (rnd_second > SAT_HI)
        begin
            sat_second = SAT_HI;
        end
        else if (rnd_second < SAT_LO)
        begin
            sat_second = SAT_LO;
        end
        else
        begin
            sat_second = rnd_second;
        end
    end

    logic                out_v_reg;
    rope_pkg::rope_out_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= rot_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg.rotated_first  <= sat_first[31:0];
        out_reg.rotated_second <= sat_second[31:0];
        out_reg.end_of_tensor  <= side_reg[SIDE_END].tensor_end;
    end

    assign result_valid = out_v_reg;
    assign result       = out_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT result_valid)
        else $error("accepted word did not reach the result port on time");

    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod_v_reg[MST-1] |-> (mod_reg[MST-1] < MW'(rope_pkg::Q30_TWO_PI)))
        else $error("angle reduction left a value at or above 2*pi");

    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        fold_v_reg |-> (fold_t_reg <= $signed(CW'(rope_pkg::Q30_HALF_PI))
                        && fold_t_reg >= -$signed(CW'(rope_pkg::Q30_HALF_PI))))
        else $error("folded angle outside half pi");

    a_cordic_align: assert property (@(posedge clk) disable iff (!rst_n)
        fold_v_reg |-> ##(rope_pkg::CORDIC_STAGES) cor_v)
        else $error("CORDIC valid out of step with its input");

    a_no_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(rot_v_reg))
        else $error("result strobe without a word in the last stage");

endmodule

@@ test/tb_rotary_position_embedding.sv @@
`timescale 1ns / 1ps

module tb_rotary_position_embedding;

    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         DRAIN_WAIT  = 60;
    localparam int         RANDOM_PHASES = 6;
    localparam int         WORDS_PER_PHASE = 320;

    typedef struct {
        rope_pkg::rope_in_t  word;
        bit                  typed;
        rope_pkg::rope_out_t want;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    rope_pkg::rope_in_t  item;
    logic                result_valid;
    rope_pkg::rope_out_t result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [23:0]         cfg_data;

    rope_pkg::rope_out_t rotation_q[$];
    logic [23:0] theta_log;
    logic [8:0]  dim_reg;
    logic [31:0] half_root[16];
    int          errors;
    int          cycles;
    bit          burst_mode;

    rotary_position_embedding i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (trial * trial <= n)
                r = trial;
        end
        return r;
    endfunction

    function automatic logic [31:0] saturate_round(input longint acc);
        longint v;
        v = (acc + (64'sd1 <<< 29)) >>> 30;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic rope_pkg::rope_out_t rotate_pair(input rope_pkg::rope_in_t w);
        rope_pkg::rope_out_t r;
        longint unsigned d, e, inv, whole, frac, ang;
        longint          t, x, y, z, dx, dy, atan, a, b;
        bit              flip;
        d = dim_reg;
        if (d < 2)
            d = 2;
        if (d > 256)
            d = 256;
        e = (64'd2 * w.pair_index * theta_log) / d;
        whole = e >> 16;
        frac = e & 64'hFFFF;
        inv = 64'd1 << 32;
        for (int k = 1; k <= 16; k++)
            if ((frac >> (16 - k)) & 1)
                inv = (inv * half_root[k-1]) >> 32;
        inv = (whole >= 33) ? 0 : inv >> whole;
        ang = ((w.position * inv) >> 2) % rope_pkg::Q30_TWO_PI;
        t = ang;
        flip = 0;
        if (t > longint'(rope_pkg::Q30_PI))
            t -= longint'(rope_pkg::Q30_TWO_PI);
        if (t > longint'(rope_pkg::Q30_HALF_PI))
        begin
            t -= longint'(rope_pkg::Q30_PI);
            flip = 1;
        end
        else if (t < -longint'(rope_pkg::Q30_HALF_PI))
        begin
            t += longint'(rope_pkg::Q30_PI);
            flip = 1;
        end
        x = rope_pkg::Q30_GAIN;
        y = 0;
        z = t;
        for (int i = 0; i < rope_pkg::CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            atan = rope_pkg::ATAN_Q30[i];
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan;
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan;
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        a = $signed(w.first_value);
        b = $signed(w.second_value);
        r.rotated_first  = saturate_round(a * x - b * y);
        r.rotated_second = saturate_round(b * x + a * y);
        r.end_of_tensor  = w.tensor_end;
        return r;
    endfunction

    // accept words, predict, and check results on the same edge
    always @(posedge clk)
    begin
        rope_pkg::rope_out_t want;
        if (rst_n && start && !busy)
            rotation_q.push_back(rotate_pair(item));
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == rope_pkg::REG_LOG2_THETA)
                theta_log <= cfg_data;
            else if (cfg_index == rope_pkg::REG_HEAD_DIM)
                dim_reg <= cfg_data[8:0];
        end
        if (rst_n && result_valid)
        begin
            if (rotation_q.size() == 0)
            begin
                $display("%t unexpected word: actual %h", $realtime, result);
                errors++;
            end
            else
            begin
                want = rotation_q.pop_front();
                if (result.rotated_first !== want.rotated_first)
                begin
                    $display("%t rotated_first: expected %h actual %h", $realtime,
                             want.rotated_first, result.rotated_first);
                    errors++;
                end
                if (result.rotated_second !== want.rotated_second)
                begin
                    $display("%t rotated_second: expected %h actual %h", $realtime,
                             want.rotated_second, result.rotated_second);
                    errors++;
                end
                if (result.end_of_tensor !== want.end_of_tensor)
                begin
                    $display("%t end_of_tensor: expected %b actual %b", $realtime,
                             want.end_of_tensor, result.end_of_tensor);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // start stays high after the word so the next one can follow at once
    task automatic send_word(input rope_pkg::rope_in_t w);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (rotation_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);
    endtask

    function automatic rope_pkg::rope_in_t random_word();
        rope_pkg::rope_in_t w;
        w.position     = 20'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom);
        w.pair_index   = 7'($urandom);
        w.first_value  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1 << 20) : $urandom;
        w.second_value = ($urandom_range(0, 3) == 0) ? -$urandom_range(0, 1 << 20) : $urandom;
        w.tensor_end   = 1'($urandom);
        return w;
    endfunction

    function automatic rope_pkg::rope_in_t mk(input logic [19:0] p, input logic [6:0] j,
                                              input logic [31:0] a, input logic [31:0] b,
                                              input logic te);
        rope_pkg::rope_in_t w;
        w.position     = p;
        w.pair_index   = j;
        w.first_value  = a;
        w.second_value = b;
        w.tensor_end   = te;
        return w;
    endfunction

    stim_row_t directed[$];

    initial
    begin
        logic [63:0]         c;
        rope_pkg::rope_out_t zero_out;
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = rope_pkg::REG_LOG2_THETA;
        cfg_data   = '0;
        errors     = 0;
        cycles     = 0;
        burst_mode = 0;
        theta_log  = rope_pkg::LOG2_THETA_RESET;
        dim_reg    = rope_pkg::HEAD_DIM_RESET;
        c = 64'd1 << 31;
        for (int k = 0; k < 16; k++)
        begin
            c = root_floor(c << 32);
            half_root[k] = c[31:0];
        end
        zero_out = '0;
        zero_out.end_of_tensor = 1'b1;

        // zero values rotate to zero whatever the angle
        directed.push_back('{mk(20'hFFFFF, 7'd127, 32'd0, 32'd0, 1'b1), 1, zero_out});
        directed.push_back('{mk(20'd0, 7'd0, 32'h7FFFFFFF, 32'h80000000, 1'b0), 0, '0});
        directed.push_back('{mk(20'd0, 7'd0, 32'h80000000, 32'h7FFFFFFF, 1'b1), 0, '0});
        directed.push_back('{mk(20'hFFFFF, 7'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0), 0, '0});
        directed.push_back('{mk(20'hFFFFF, 7'd127, 32'h80000000, 32'h80000000, 1'b1), 0, '0});
        directed.push_back('{mk(20'd1, 7'd1, 32'h00010000, 32'h00000000, 1'b0), 0, '0});
        directed.push_back('{mk(20'd3, 7'd0, 32'hFFFF0000, 32'h00010000, 1'b0), 0, '0});
        directed.push_back('{mk(20'd100, 7'd63, 32'h00018000, 32'hFFFE8000, 1'b0), 0, '0});
        directed.push_back('{mk(20'd100, 7'd64, 32'h00000001, 32'hFFFFFFFF, 1'b1), 0, '0});

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[n])
        begin
            send_word(directed[n].word);
            if (directed[n].typed)
            begin
                drain();
                // the typed row must predict to its own value
                if (rotate_pair(directed[n].word) !== directed[n].want)
                begin
                    $display("%t table row %0d: expected %h actual %h", $realtime, n,
                             directed[n].want, rotate_pair(directed[n].word));
                    errors++;
                end
            end
        end
        drain();

        // extreme settings, odd dims, dims out of range, unknown indexes
        write_reg(rope_pkg::REG_LOG2_THETA, 24'd0);
        write_reg(rope_pkg::REG_HEAD_DIM, 24'd2);
        for (int n = 0; n < 4; n++)
            send_word(random_word());
        drain();
        write_reg(rope_pkg::REG_LOG2_THETA, 24'hFFFFFF);
        write_reg(rope_pkg::REG_HEAD_DIM, 24'd0);
        write_reg(REG_SPARE_A, 24'h123456);
        write_reg(REG_SPARE_B, 24'hFFFFFF);
        for (int n = 0; n < 4; n++)
            send_word(random_word());
        drain();
        write_reg(rope_pkg::REG_HEAD_DIM, 24'hFFFFFF);
        write_reg(rope_pkg::REG_LOG2_THETA, 24'd65536);
        for (int n = 0; n < 4; n++)
            send_word(random_word());
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph % 3)
                0: write_reg(rope_pkg::REG_LOG2_THETA, rope_pkg::LOG2_THETA_RESET);
                1: write_reg(rope_pkg::REG_LOG2_THETA, 24'($urandom));
                default: write_reg(rope_pkg::REG_LOG2_THETA, 24'($urandom_range(0, 1 << 20)));
            endcase
            write_reg(rope_pkg::REG_HEAD_DIM, (ph == 0) ? 24'd256 : 24'($urandom));
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (n % 40 == 0)
                    burst_mode = ($urandom_range(0, 2) == 0);
                if (ph == 2 && n == WORDS_PER_PHASE / 2)
                    drain();
                send_word(random_word());
            end
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/rope_pkg.sv
rtl/core/rope_div.sv
rtl/core/rope_cordic.sv
rtl/core/rotary_position_embedding.sv
test/tb_rotary_position_embedding.sv
